// ===== design/sprite_quad_vertex_generator_assert.svh =====
// Assertion macros for the sprite quad vertex generator.
`ifndef SPRITE_QUAD_VERTEX_GENERATOR_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SQVG_ASSERT_IMPL(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("sqvg assertion failed");

`define SQVG_ASSERT_NEVER(name, cond) \
name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("sqvg assertion failed");

`else

`define SQVG_ASSERT_IMPL(name, ante, cons)

`define SQVG_ASSERT_NEVER(name, cond)

`endif

`endif

// ===== design/sqvg_pkg.sv =====
package sqvg_pkg;

	localparam int QDEPTH_DEF = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0_XY = 3'd0,
		REG_ROW0_ZW = 3'd1,
		REG_ROW1_XY = 3'd2,
		REG_ROW1_ZW = 3'd3,
		REG_ROW2_XY = 3'd4,
		REG_ROW2_ZW = 3'd5
	} cfg_reg_t;

	localparam logic [CFG_DATA_W-1:0] ROW0_XY_RST = 64'h0000_0000_0001_0000;
	localparam logic [CFG_DATA_W-1:0] ROW0_ZW_RST = 64'h0000_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] ROW1_XY_RST = 64'h0001_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] ROW1_ZW_RST = 64'h0000_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] ROW2_XY_RST = 64'h0000_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] ROW2_ZW_RST = 64'h0000_0000_0001_0000;

	localparam logic [1:0] CORNER_ORIGIN = 2'd0;
	localparam logic [1:0] CORNER_UL     = 2'd1;
	localparam logic [1:0] CORNER_UR     = 2'd2;
	localparam logic [1:0] CORNER_BR     = 2'd3;

	typedef struct packed {
		logic                  wen;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// one queued sprite: both corner coordinates already formed at 33 bits
	typedef struct packed {
		logic signed [32:0] x0;
		logic signed [32:0] x1;
		logic signed [32:0] y0;
		logic signed [32:0] y1;
		logic signed [31:0] z;
		logic [31:0]        color;
		logic [63:0]        uv_low;
		logic [63:0]        uv_high;
	} sprite_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic [31:0]        color;
		logic [1:0]         corner;
		logic               last;
	} vert_t;

	typedef struct packed {
		logic       issue;
		logic       q_pop;
		logic [1:0] corner;
	} bk_stat_t;

endpackage

// ===== design/sprite_quad_vertex_generator.sv =====
// Sprite quad expansion: each sprite request yields four vertices (origin, upper left,
// upper right, bottom right), each transformed by the configured 3x4 Q16.16 affine
// matrix with floor and 32-bit saturation, carrying its UV pair and the packed colour.
// The back end issues one vertex per cycle from the sprite queue while the pipeline can
// advance, and the result port delivers one vertex per cycle while pop is high. Each
// issued vertex passes the s1, s2 and s3 registers before the result ports. Up to
// QUEUE_DEPTH sprites wait in the queue, so requests are taken while results are stalled
// until it fills. Configuration writes are only allowed while the block is idle.
`include "sprite_quad_vertex_generator_assert.svh"

module sprite_quad_vertex_generator import sqvg_pkg::*; #(
	parameter int QUEUE_DEPTH = QDEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic signed [31:0]    pos_x,
	input  logic signed [31:0]    pos_y,
	input  logic signed [31:0]    pos_z,
	input  logic signed [31:0]    size_x,
	input  logic signed [31:0]    size_y,
	input  logic [16:0]           red,
	input  logic [16:0]           green,
	input  logic [16:0]           blue,
	input  logic [16:0]           alpha,
	input  logic [63:0]           uv_low,
	input  logic [63:0]           uv_high,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  empty,
	input  logic                  pop,
	output logic signed [31:0]    vert_x,
	output logic signed [31:0]    vert_y,
	output logic signed [31:0]    vert_z,
	output logic [15:0]           tex_u,
	output logic [15:0]           tex_v,
	output logic [31:0]           packed_color,
	output logic [1:0]            corner,
	output logic                  last
);

	localparam int SPR_W = $bits(sprite_t);

	sprite_t  spr_in;
	sprite_t  spr_head;
	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_empty;
	cfg_wr_t  cfg;
	vert_t    vert;
	bk_stat_t stat;

	assign cfg.wen   = cfg_wen;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	sqvg_front u_front (
		.push    (push),
		.full    (full),
		.pos_x   (pos_x),
		.pos_y   (pos_y),
		.pos_z   (pos_z),
		.size_x  (size_x),
		.size_y  (size_y),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.alpha   (alpha),
		.uv_low  (uv_low),
		.uv_high (uv_high),
		.q_full  (q_full),
		.q_push  (q_push),
		.spr     (spr_in)
	);

	sqvg_queue #(
		.DATA_W (SPR_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (spr_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (spr_head),
		.empty  (q_empty)
	);

	sqvg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.spr     (spr_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.vert    (vert),
		.empty   (empty),
		.pop     (pop),
		.stat    (stat)
	);

	assign vert_x       = vert.x;
	assign vert_y       = vert.y;
	assign vert_z       = vert.z;
	assign tex_u        = vert.tex_u;
	assign tex_v        = vert.tex_v;
	assign packed_color = vert.color;
	assign corner       = vert.corner;
	assign last         = vert.last;

	`SQVG_ASSERT_IMPL(a_last_on_br, !empty, last == (corner == CORNER_BR))
	`SQVG_ASSERT_IMPL(a_retire_on_br, stat.q_pop, stat.issue && stat.corner == CORNER_BR)
	`SQVG_ASSERT_NEVER(a_issue_from_empty, q_empty && stat.issue)

endmodule

// ===== design/sqvg_queue.sv =====
module sqvg_queue #(
	parameter int DATA_W = 1,
	parameter int DEPTH  = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] din,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] dout,
	output logic              empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [CW-1:0]     cnt_q;
	logic              do_push;
	logic              do_pop;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (do_pop) begin
				rd_q <= next_ptr(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/sqvg_front.sv =====
module sqvg_front import sqvg_pkg::*; (
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] size_x,
	input  logic signed [31:0] size_y,
	input  logic [16:0]        red,
	input  logic [16:0]        green,
	input  logic [16:0]        blue,
	input  logic [16:0]        alpha,
	input  logic [63:0]        uv_low,
	input  logic [63:0]        uv_high,
	input  logic               q_full,
	output logic               q_push,
	output sprite_t            spr
);

	// (c * 255) >> 16, clamped to one byte
	function automatic logic [7:0] chan8(input logic [16:0] c);
		logic [24:0] p;
		p = {c, 8'b0} - 25'(c);
		if (p[24]) begin
			return 8'hFF;
		end
		return p[23:16];
	endfunction

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		spr.x0      = 33'(pos_x);
		spr.y0      = 33'(pos_y);
		spr.x1      = 33'(pos_x) + 33'(size_x);
		spr.y1      = 33'(pos_y) + 33'(size_y);
		spr.z       = pos_z;
		spr.color   = {chan8(alpha), chan8(blue), chan8(green), chan8(red)};
		spr.uv_low  = uv_low;
		spr.uv_high = uv_high;
	end

endmodule

// ===== design/sqvg_back.sv =====
module sqvg_back import sqvg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_wr_t  cfg,
	input  sprite_t  spr,
	input  logic     q_empty,
	output logic     q_pop,
	output vert_t    vert,
	output logic     empty,
	input  logic     pop,
	output bk_stat_t stat
);

	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic [31:0] color;
		logic [1:0]  corner;
		logic        last;
	} side_t;

	logic [63:0]        row_xy_q [3];
	logic [63:0]        row_zw_q [3];
	logic signed [31:0] coef [3][3];
	logic signed [31:0] trans [3];

	logic [1:0]         corner_q;
	logic               issue;
	logic               adv1, adv2, adv3;
	logic               v_s1, v_s2, v_s3;

	logic signed [32:0] pt [3];
	logic [63:0]        uvw;
	logic [31:0]        uvh;
	side_t              side_d;

	logic signed [64:0] prod_d [3][3];
	logic signed [64:0] prod_s1 [3][3];
	side_t              side_s1;
	logic signed [66:0] sum_d [3];
	logic signed [66:0] sum_s2 [3];
	side_t              side_s2;
	logic signed [51:0] tot [3];
	logic [31:0]        res_d [3];
	logic [31:0]        res_s3 [3];
	side_t              side_s3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_xy_q[0] <= ROW0_XY_RST;
			row_zw_q[0] <= ROW0_ZW_RST;
			row_xy_q[1] <= ROW1_XY_RST;
			row_zw_q[1] <= ROW1_ZW_RST;
			row_xy_q[2] <= ROW2_XY_RST;
			row_zw_q[2] <= ROW2_ZW_RST;
		end else if (cfg.wen) begin
			case (cfg.index)
				REG_ROW0_XY: row_xy_q[0] <= cfg.data;
				REG_ROW0_ZW: row_zw_q[0] <= cfg.data;
				REG_ROW1_XY: row_xy_q[1] <= cfg.data;
				REG_ROW1_ZW: row_zw_q[1] <= cfg.data;
				REG_ROW2_XY: row_xy_q[2] <= cfg.data;
				REG_ROW2_ZW: row_zw_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			coef[r][0] = row_xy_q[r][31:0];
			coef[r][1] = row_xy_q[r][63:32];
			coef[r][2] = row_zw_q[r][31:0];
			trans[r]   = row_zw_q[r][63:32];
		end
	end

	// elastic pipeline handshake
	assign adv3  = !v_s3 || pop;
	assign adv2  = !v_s2 || adv3;
	assign adv1  = !v_s1 || adv2;
	assign issue = !q_empty && adv1;
	assign q_pop = issue && (corner_q == CORNER_BR);
	assign empty = !v_s3;

	assign stat.issue  = issue;
	assign stat.q_pop  = q_pop;
	assign stat.corner = corner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= CORNER_ORIGIN;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			if (issue) begin
				corner_q <= corner_q + 2'd1;
			end
			if (adv1) begin
				v_s1 <= issue;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// corner selection
	always_comb begin
		pt[0] = (corner_q == CORNER_UR || corner_q == CORNER_BR) ? spr.x1 : spr.x0;
		pt[1] = (corner_q == CORNER_UL || corner_q == CORNER_UR) ? spr.y1 : spr.y0;
		pt[2] = 33'(spr.z);
		uvw   = corner_q[1] ? spr.uv_high : spr.uv_low;
		uvh   = corner_q[0] ? uvw[63:32] : uvw[31:0];
		side_d.tex_u  = uvh[15:0];
		side_d.tex_v  = uvh[31:16];
		side_d.color  = spr.color;
		side_d.corner = corner_q;
		side_d.last   = (corner_q == CORNER_BR);
	end

	// s1: nine products
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int i = 0; i < 3; i++) begin
				prod_d[r][i] = coef[r][i] * pt[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			prod_s1 <= prod_d;
			side_s1 <= side_d;
		end
	end

	// s2: row sums
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum_d[r] = 67'(prod_s1[r][0]) + 67'(prod_s1[r][1]) + 67'(prod_s1[r][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			sum_s2  <= sum_d;
			side_s2 <= side_s1;
		end
	end

	// s3: floor, translate, saturate
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			tot[r] = 52'($signed(sum_s2[r][66:16])) + 52'(trans[r]);
			if (&tot[r][51:31] || ~|tot[r][51:31]) begin
				res_d[r] = tot[r][31:0];
			end else begin
				res_d[r] = tot[r][51] ? SAT_MIN : SAT_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			res_s3  <= res_d;
			side_s3 <= side_s2;
		end
	end

	always_comb begin
		vert.x      = res_s3[0];
		vert.y      = res_s3[1];
		vert.z      = res_s3[2];
		vert.tex_u  = side_s3.tex_u;
		vert.tex_v  = side_s3.tex_v;
		vert.color  = side_s3.color;
		vert.corner = side_s3.corner;
		vert.last   = side_s3.last;
	end

endmodule
